// ===== rtl/mask_tone_sample_generator_core_macros.svh =====
// Assertion shorthands shared by the core's modules.
`ifndef MASK_TONE_SAMPLE_GENERATOR_CORE_MACROS_SVH
`define MASK_TONE_SAMPLE_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define MTSG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTSG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mtsg_pkg.sv =====
package mtsg_pkg;

  localparam int WORD_BITS        = 32;
  localparam int INDEX_BITS       = 10;
  localparam int LEVEL_BITS       = 27;
  localparam int LEVEL_COUNT_BITS = 11;
  localparam int OUT_BITS         = 16;
  localparam int STEP_BITS        = 32;
  localparam int SPS_BITS         = 16;
  localparam int AMP_BITS         = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_TICKS      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_COUNT       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_STEP        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BINARY_HIGH_LEVEL = 3'd4;

  // remainder unit: bits of the random word consumed per cycle
  localparam int DIV_STEP_BITS  = 4;
  localparam int DIV_CYCLES     = WORD_BITS / DIV_STEP_BITS;
  localparam int DIV_COUNT_BITS = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = 16'sh8000;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef struct packed {
    logic [STEP_BITS-1:0]        phase_step;
    logic [SPS_BITS-1:0]         symbol_ticks;
    logic [LEVEL_COUNT_BITS-1:0] level_count;
    logic [AMP_BITS-1:0]         level_step;
    logic [AMP_BITS-1:0]         binary_high_level;
  } cfg_t;

  // one queued tick: whether it draws, and the drawn index
  typedef struct packed {
    logic                  draw;
    logic [INDEX_BITS-1:0] k;
  } cmd_t;

  function automatic logic [LEVEL_COUNT_BITS-1:0] clamp_levels(
      logic [LEVEL_COUNT_BITS-1:0] n, int unsigned max_levels);
    if (n < LEVEL_COUNT_BITS'(2)) return LEVEL_COUNT_BITS'(2);
    if (n > LEVEL_COUNT_BITS'(max_levels)) return LEVEL_COUNT_BITS'(max_levels);
    return n;
  endfunction

  // quarter-wave sine entry, Q30 Taylor series to x^15, elaboration only
  function automatic logic [63:0] sine_rom_entry(int unsigned a, int unsigned addr_bits,
                                                 int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] full;
    logic [63:0] v;
    longint      sum;
    x    = (64'(a) * PI_HALF_Q30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    full = (64'd1 << (sample_bits - 1)) - 64'd1;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (64'(sum) * full + (64'd1 << 29)) >> 30;
    return (v > full) ? full : v;
  endfunction

endpackage

// ===== rtl/mtsg_if.sv =====
interface mtsg_in_if import mtsg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface mtsg_out_if import mtsg_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [OUT_BITS-1:0]   in_phase;
  logic signed [OUT_BITS-1:0]   quadrature;
  logic        [INDEX_BITS-1:0] symbol_index;

  modport source (output valid, output in_phase, output quadrature, output symbol_index,
                  input ready);
  modport sink   (input valid, input in_phase, input quadrature, input symbol_index,
                  output ready);
endinterface

interface mtsg_cfg_if import mtsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mtsg_fifo.sv =====
module mtsg_fifo import mtsg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mtsg_front.sv =====
`include "mask_tone_sample_generator_core_macros.svh"

module mtsg_front import mtsg_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int MAX_LEVELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg_regs,
  mtsg_in_if.sink     tick,
  output logic        push_valid,
  output cmd_t        push_data,
  input  logic        full
);

  localparam int CMP_BITS = (COUNT_BITS > SPS_BITS) ? COUNT_BITS : SPS_BITS;
  localparam logic [CMP_BITS-1:0] COUNT_MAX = CMP_BITS'({COUNT_BITS{1'b1}});
  localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST = DIV_COUNT_BITS'(DIV_CYCLES - 1);

  typedef enum logic [1:0] {F_IDLE, F_DIVIDE, F_PUSH} state_t;

  state_t                      state;
  logic                        first_pending;
  logic [COUNT_BITS-1:0]       tick_count;
  logic [WORD_BITS-1:0]        word;
  logic [LEVEL_COUNT_BITS-1:0] rem;
  logic [DIV_COUNT_BITS-1:0]   div_count;

  logic [LEVEL_COUNT_BITS-1:0] m_eff;
  logic [CMP_BITS-1:0]         sps_ext;
  logic [CMP_BITS-1:0]         sps_nz;
  logic [CMP_BITS-1:0]         sps_lim;
  logic                        accept;
  logic                        draw;
  logic [WORD_BITS-1:0]        word_step;
  logic [LEVEL_COUNT_BITS-1:0] rem_step;

  assign m_eff   = clamp_levels(cfg_regs.level_count, MAX_LEVELS);
  assign sps_ext = CMP_BITS'(cfg_regs.symbol_ticks);
  assign sps_nz  = (sps_ext == '0) ? CMP_BITS'(1) : sps_ext;
  assign sps_lim = (sps_nz > COUNT_MAX) ? COUNT_MAX : sps_nz;

  assign tick.ready = (state == F_IDLE) && !full;
  assign accept     = tick.valid && tick.ready;
  assign draw       = first_pending || (CMP_BITS'(tick_count) >= sps_lim);

  assign push_valid = (state == F_PUSH) || (accept && !draw);
  assign push_data  = (state == F_PUSH) ? cmd_t'{draw: 1'b1, k: rem[INDEX_BITS-1:0]}
                                        : cmd_t'{draw: 1'b0, k: '0};

  // restoring remainder, several word bits per cycle
  always_comb begin
    logic [LEVEL_COUNT_BITS-1:0] r;
    logic [WORD_BITS-1:0]        w;
    logic [LEVEL_COUNT_BITS:0]   t;
    r = rem;
    w = word;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {r, w[WORD_BITS-1]};
      w = w << 1;
      if (t >= {1'b0, m_eff}) t = t - {1'b0, m_eff};
      r = t[LEVEL_COUNT_BITS-1:0];
    end
    rem_step  = r;
    word_step = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      first_pending <= 1'b1;
      tick_count    <= '0;
      div_count     <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            tick_count <= draw ? COUNT_BITS'(1)
                        : ((tick_count == '1) ? tick_count : tick_count + 1'b1);
            if (draw) begin
              first_pending <= 1'b0;
              word          <= tick.random_word;
              rem           <= '0;
              div_count     <= '0;
              state         <= F_DIVIDE;
            end
          end
        end
        F_DIVIDE: begin
          word      <= word_step;
          rem       <= rem_step;
          div_count <= div_count + 1'b1;
          if (div_count == DIV_LAST) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `MTSG_ASSERT_IMP(a_rem_below_levels, clk, rst, state == F_PUSH, rem < m_eff, "drawn index not below level count")
  `MTSG_ASSERT_NXT(a_draw_starts_divide, clk, rst, accept && draw, state == F_DIVIDE, "drawing tick did not start remainder")
  `MTSG_ASSERT_IMP(a_first_draw_on_accept, clk, rst, $fell(first_pending), $past(accept), "first draw cleared without a tick")

endmodule

// ===== rtl/mtsg_back.sv =====
`include "mask_tone_sample_generator_core_macros.svh"

module mtsg_back import mtsg_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_LEVELS      = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg_regs,
  input  logic       pop_valid,
  input  cmd_t       pop_data,
  output logic       pop,
  mtsg_out_if.source sample
);

  localparam int ROM_DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int RAW       = TABLE_ADDR_BITS + 1;
  localparam int MAG_BITS  = SAMPLE_BITS - 1;
  localparam int PROD_BITS = LEVEL_BITS + SAMPLE_BITS;
  localparam logic [RAW-1:0] ROM_LAST = RAW'(1 << TABLE_ADDR_BITS);
  localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(32767);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = PROD_BITS'(-32768);

  logic [MAG_BITS-1:0] rom [ROM_DEPTH];

  for (genvar a = 0; a < ROM_DEPTH; a++) begin : g_rom
    localparam logic [MAG_BITS-1:0] ENTRY =
      MAG_BITS'(sine_rom_entry(a, TABLE_ADDR_BITS, SAMPLE_BITS));
    assign rom[a] = ENTRY;
  end

  function automatic logic [RAW-1:0] rom_index(logic mirror, logic [TABLE_ADDR_BITS-1:0] a);
    return mirror ? ROM_LAST - RAW'(a) : RAW'(a);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] saturate(logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] s;
    s = p >>> (SAMPLE_BITS - 1);
    if (s > SAT_HI) return OUT_MAX;
    if (s < SAT_LO) return OUT_MIN;
    return s[OUT_BITS-1:0];
  endfunction

  logic                          adv;
  logic                          v1, v2, v3;
  logic [PHASE_BITS-1:0]         phase_acc;
  logic signed [LEVEL_BITS-1:0]  current_level;
  logic [INDEX_BITS-1:0]         current_index;

  logic [RAW-1:0]                sin_idx1, cos_idx1;
  logic                          sin_neg1, cos_neg1;
  logic [MAG_BITS-1:0]           sin_mag2, cos_mag2;
  logic                          sin_neg2, cos_neg2;
  logic signed [LEVEL_BITS-1:0]  lvl2;
  logic [INDEX_BITS-1:0]         idx2;
  logic signed [PROD_BITS-1:0]   prod_i3, prod_q3;
  logic [INDEX_BITS-1:0]         idx3;

  logic [TABLE_ADDR_BITS+1:0]    phase_top;
  logic [1:0]                    quad_s, quad_c;
  logic [TABLE_ADDR_BITS-1:0]    addr;
  logic [LEVEL_COUNT_BITS-1:0]   m_eff;
  logic signed [12:0]            coef;
  logic signed [29:0]            level_prod;
  logic signed [LEVEL_BITS-1:0]  level_new;
  logic signed [SAMPLE_BITS-1:0] cos_val, sin_val;

  assign adv = !sample.valid || sample.ready;
  assign pop = adv && pop_valid;

  assign phase_top = phase_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
  assign quad_s    = phase_top[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  assign quad_c    = quad_s + 2'd1;
  assign addr      = phase_top[TABLE_ADDR_BITS-1:0];

  assign m_eff      = clamp_levels(cfg_regs.level_count, MAX_LEVELS);
  assign coef       = $signed({2'b00, pop_data.k, 1'b0}) - $signed({2'b00, m_eff}) + 13'sd1;
  assign level_prod = coef * $signed({1'b0, cfg_regs.level_step});
  // two levels: on-off keying
  assign level_new  = (m_eff == LEVEL_COUNT_BITS'(2))
                      ? ((pop_data.k != '0) ? $signed(LEVEL_BITS'(cfg_regs.binary_high_level))
                                            : '0)
                      : level_prod[LEVEL_BITS-1:0];

  assign cos_val = cos_neg2 ? -$signed({1'b0, cos_mag2}) : $signed({1'b0, cos_mag2});
  assign sin_val = sin_neg2 ? -$signed({1'b0, sin_mag2}) : $signed({1'b0, sin_mag2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      sample.valid  <= 1'b0;
      phase_acc     <= '0;
      current_level <= '0;
      current_index <= '0;
    end else if (adv) begin
      v1           <= pop_valid;
      v2           <= v1;
      v3           <= v2;
      sample.valid <= v3;
      if (pop_valid) begin
        phase_acc <= phase_acc + PHASE_BITS'(cfg_regs.phase_step);
        if (pop_data.draw) begin
          current_level <= level_new;
          current_index <= pop_data.k;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop_valid) begin
        sin_idx1 <= rom_index(quad_s[0], addr);
        cos_idx1 <= rom_index(quad_c[0], addr);
        sin_neg1 <= quad_s[1];
        cos_neg1 <= quad_c[1];
      end
      sin_mag2            <= rom[sin_idx1];
      cos_mag2            <= rom[cos_idx1];
      sin_neg2            <= sin_neg1;
      cos_neg2            <= cos_neg1;
      lvl2                <= current_level;
      idx2                <= current_index;
      prod_i3             <= lvl2 * cos_val;
      prod_q3             <= lvl2 * sin_val;
      idx3                <= idx2;
      sample.in_phase     <= saturate(prod_i3);
      sample.quadrature   <= saturate(prod_q3);
      sample.symbol_index <= idx3;
    end
  end

  `MTSG_ASSERT_IMP(a_no_pop_on_stall, clk, rst, sample.valid && !sample.ready, !pop, "queue popped while output stalled")
  `MTSG_ASSERT_NXT(a_phase_holds, clk, rst, !pop, $stable(phase_acc), "phase moved without a transaction")
  `MTSG_ASSERT_NXT(a_bubble_stays_empty, clk, rst, adv && !v3, !sample.valid, "output valid from an empty stage")

endmodule

// ===== rtl/mask_tone_sample_generator_core.sv =====
// M-ary amplitude-keyed tone source: each input transaction is one sample tick and
// yields one output transaction holding level*cos, level*sin of an NCO phase and the
// symbol index in force. Ticks that do not start a new symbol are taken one per clock while
// the queue is not full; a tick that draws a new symbol (the first after reset, then each
// symbol boundary) holds off further input from its acceptance, through the remainder unit
// that forms random_word mod M four bits per cycle, until its index is queued. A two-entry queue
// separates this from the sample pipeline, which turns out one sample per clock unless the
// output stalls, through registered level, ROM read, multiply and saturate-to-output stages.
// Registers: 0 phase_step, 1 symbol length in ticks, 2 level count M, 3 level_step,
// 4 binary_high_level; write them only while no tick is in flight.
module mask_tone_sample_generator_core import mtsg_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_LEVELS      = 1024,
  parameter int COUNT_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst,
  mtsg_cfg_if.sink   cfg,
  mtsg_in_if.sink    tick,
  mtsg_out_if.source sample
);

  cfg_t cfg_regs;
  logic push_valid;
  cmd_t push_data;
  logic full;
  logic pop;
  logic pop_valid;
  cmd_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.phase_step        <= '0;
      cfg_regs.symbol_ticks      <= SPS_BITS'(1);
      cfg_regs.level_count       <= LEVEL_COUNT_BITS'(2);
      cfg_regs.level_step        <= '0;
      cfg_regs.binary_high_level <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PHASE_STEP:        cfg_regs.phase_step        <= cfg.data[STEP_BITS-1:0];
        REG_SYMBOL_TICKS:      cfg_regs.symbol_ticks      <= cfg.data[SPS_BITS-1:0];
        REG_LEVEL_COUNT:       cfg_regs.level_count       <= cfg.data[LEVEL_COUNT_BITS-1:0];
        REG_LEVEL_STEP:        cfg_regs.level_step        <= cfg.data[AMP_BITS-1:0];
        REG_BINARY_HIGH_LEVEL: cfg_regs.binary_high_level <= cfg.data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  mtsg_front #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .tick       (tick),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (full)
  );

  mtsg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  mtsg_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .MAX_LEVELS      (MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .sample    (sample)
  );

endmodule
